### rtl/psa_pkg.sv
// psa_pkg: shared constants, codes and control structs of the pooled slot allocator.
// No dependencies; compiled first.
package psa_pkg;

  // Default sizing, handed to the top-level parameters
  localparam int NUM_POOLS_DEF      = 8;
  localparam int SLOTS_PER_POOL_DEF = 1024;

  // Fixed field widths of the channels and the configuration port
  localparam int FUNC_W   = 1;
  localparam int BATCH_W  = 3;
  localparam int OFFSET_W = 10;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 11;

  // Reset value of slots_per_batch
  localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 1'b0;
  localparam logic [FUNC_W-1:0] FUNC_RELEASE = 1'b1;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_REUSED   = 3'd0,
    ST_FRESH    = 3'd1,
    ST_OPENED   = 3'd2,
    ST_NO_SPACE = 3'd3,
    ST_RELEASED = 3'd4,
    ST_REJECTED = 3'd5
  } status_t;

  // Controller to datapath commands
  typedef struct packed {
    logic capture;   // latch the request transfer
    logic commit;    // apply the decision, load result
    logic load_mem;  // take the slot number from queue memory read data
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic need_read; // decision pops a pool queue
  } sts_t;

endpackage

### rtl/psa_if.sv
// psa_if: valid/ready channel interfaces for requests and results.
// Depends on psa_pkg for field widths.
interface psa_req_if;
  logic                           valid;
  logic                           ready;
  logic [psa_pkg::FUNC_W-1:0]     func;
  logic [psa_pkg::BATCH_W-1:0]    batch;
  logic [psa_pkg::OFFSET_W-1:0]   slot_offset;

  modport source (output valid, func, batch, slot_offset, input ready);
  modport sink   (input valid, func, batch, slot_offset, output ready);
endinterface

interface psa_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [psa_pkg::STATUS_W-1:0]   status;
  logic [psa_pkg::BATCH_W-1:0]    out_batch;
  logic [psa_pkg::OFFSET_W-1:0]   out_offset;

  modport source (output valid, status, out_batch, out_offset, input ready);
  modport sink   (input valid, status, out_batch, out_offset, output ready);
endinterface

### rtl/psa_dp.sv
// psa_dp: allocator datapath: per-pool counters, queue memory, decision logic,
// limit register and result register. Depends on psa_pkg.
module psa_dp #(
  parameter int NUM_POOLS      = psa_pkg::NUM_POOLS_DEF,
  parameter int SLOTS_PER_POOL = psa_pkg::SLOTS_PER_POOL_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  psa_pkg::cmd_t                 cmd,
  output psa_pkg::sts_t                 sts,
  input  logic [psa_pkg::FUNC_W-1:0]    in_func,
  input  logic [psa_pkg::BATCH_W-1:0]   in_batch,
  input  logic [psa_pkg::OFFSET_W-1:0]  in_offset,
  input  logic                          cfg_we,
  input  logic [psa_pkg::CFG_W-1:0]     cfg_wdata,
  output logic [psa_pkg::STATUS_W-1:0]  res_status,
  output logic [psa_pkg::BATCH_W-1:0]   res_batch,
  output logic [psa_pkg::OFFSET_W-1:0]  res_offset
);
  import psa_pkg::*;

  localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int OW    = $clog2(SLOTS_PER_POOL);
  localparam int CW    = OW + 1;
  localparam int NW    = $clog2(NUM_POOLS + 1);
  localparam int DEPTH = NUM_POOLS * (2 ** OW);

  // Clamp a written limit into 1..SLOTS_PER_POOL
  function automatic logic [CW-1:0] eff_limit(input logic [CFG_W-1:0] d);
    logic [CW-1:0] r;
    if (d == '0) r = CW'(1);
    else if (32'(d) > 32'(SLOTS_PER_POOL)) r = CW'(SLOTS_PER_POOL);
    else r = CW'(d);
    return r;
  endfunction

  // Queue pointer advance, wraps at SLOTS_PER_POOL
  function automatic logic [OW-1:0] ptr_inc(input logic [OW-1:0] x);
    return (x == OW'(SLOTS_PER_POOL - 1)) ? '0 : x + OW'(1);
  endfunction

  // Captured request
  logic [FUNC_W-1:0]   req_func;
  logic [BATCH_W-1:0]  req_batch;
  logic [OFFSET_W-1:0] req_offset;

  // Pool state
  logic [NW-1:0] opened;
  logic [CW-1:0] high_water [NUM_POOLS];
  logic [OW-1:0] head       [NUM_POOLS];
  logic [OW-1:0] tail       [NUM_POOLS];
  logic [CW-1:0] count      [NUM_POOLS];
  logic [CW-1:0] lim;

  // Queue memory, contents undefined until written
  logic [OW-1:0] qmem [DEPTH];
  logic [OW-1:0] qmem_rd;

  // Result register
  status_t             out_status;
  logic [BATCH_W-1:0]  out_batch;
  logic [OFFSET_W-1:0] out_offset;

  // Decision signals
  logic [NUM_POOLS-1:0] avail;
  logic                 found;
  logic [PW-1:0]        sel;
  logic [PW-1:0]        new_pool;
  logic [PW-1:0]        rel_idx;
  logic                 rel_bad;
  status_t              dec_status;
  logic [PW-1:0]        dec_pool;
  logic [OW-1:0]        dec_off;

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_func   <= in_func;
      req_batch  <= in_batch;
      req_offset <= in_offset;
    end
  end

  // Per-pool availability: opened and not full
  always_comb begin
    for (int p = 0; p < NUM_POOLS; p++) begin
      avail[p] = (NW'(p) < opened) && !((count[p] == '0) && (high_water[p] >= lim));
    end
  end

  // Lowest available pool
  always_comb begin
    found = 1'b0;
    sel   = '0;
    for (int p = NUM_POOLS - 1; p >= 0; p--) begin
      if (avail[p]) begin
        found = 1'b1;
        sel   = PW'(p);
      end
    end
  end

  assign new_pool = PW'(opened);
  assign rel_idx  = PW'(req_batch);
  assign rel_bad  = (32'(req_batch) >= 32'(opened)) ||
                    (32'(req_batch) >= 32'(NUM_POOLS)) ||
                    (32'(req_offset) >= 32'(high_water[rel_idx])) ||
                    (32'(count[rel_idx]) >= 32'(SLOTS_PER_POOL));

  // Request decision
  always_comb begin
    dec_status = ST_NO_SPACE;
    dec_pool   = '0;
    dec_off    = '0;
    if (req_func == FUNC_ALLOC) begin
      if (found) begin
        dec_pool = sel;
        if (count[sel] != '0) begin
          dec_status = ST_REUSED;
        end else begin
          dec_status = ST_FRESH;
          dec_off    = OW'(high_water[sel]);
        end
      end else if (opened != NW'(NUM_POOLS)) begin
        dec_status = ST_OPENED;
        dec_pool   = new_pool;
      end
    end else if (rel_bad) begin
      dec_status = ST_REJECTED;
    end else begin
      dec_status = ST_RELEASED;
    end
  end

  assign sts.need_read = (dec_status == ST_REUSED);

  // Pool state update and limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      opened <= '0;
      lim    <= eff_limit(CFG_RESET);
      for (int p = 0; p < NUM_POOLS; p++) begin
        high_water[p] <= '0;
        head[p]       <= '0;
        tail[p]       <= '0;
        count[p]      <= '0;
      end
    end else begin
      if (cfg_we) begin
        lim <= eff_limit(cfg_wdata);
      end
      if (cmd.commit) begin
        case (dec_status)
          ST_REUSED: begin
            head[sel]  <= ptr_inc(head[sel]);
            count[sel] <= count[sel] - CW'(1);
          end
          ST_FRESH: begin
            high_water[sel] <= high_water[sel] + CW'(1);
          end
          ST_OPENED: begin
            opened               <= opened + NW'(1);
            high_water[new_pool] <= CW'(1);
            head[new_pool]       <= '0;
            tail[new_pool]       <= '0;
            count[new_pool]      <= '0;
          end
          ST_RELEASED: begin
            tail[rel_idx]  <= ptr_inc(tail[rel_idx]);
            count[rel_idx] <= count[rel_idx] + CW'(1);
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Queue memory: push on release, registered pop read on reuse
  always_ff @(posedge clk) begin
    if (cmd.commit && (dec_status == ST_RELEASED)) begin
      qmem[{rel_idx, tail[rel_idx]}] <= OW'(req_offset);
    end
    if (cmd.commit && (dec_status == ST_REUSED)) begin
      qmem_rd <= qmem[{sel, head[sel]}];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status <= dec_status;
      out_batch  <= BATCH_W'(dec_pool);
      out_offset <= OFFSET_W'(dec_off);
    end else if (cmd.load_mem) begin
      out_offset <= OFFSET_W'(qmem_rd);
    end
  end

  assign res_status = out_status;
  assign res_batch  = out_batch;
  assign res_offset = out_offset;

endmodule

### rtl/psa_ctrl.sv
// psa_ctrl: allocator controller: request/result handshakes and sequencing of
// capture, commit and queue read. Depends on psa_pkg.
module psa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output psa_pkg::cmd_t cmd,
  input  psa_pkg::sts_t sts
);
  import psa_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_READ
  } state_t;

  state_t state;
  logic   can_load;

  // Result register is free, or drains on this edge
  assign can_load = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  // Command decode
  always_comb begin
    cmd.capture  = (state == S_IDLE) && in_valid;
    cmd.commit   = (state == S_DECIDE) && can_load;
    cmd.load_mem = (state == S_READ);
  end

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (can_load) begin
            if (sts.need_read) begin
              state <= S_READ;
            end else begin
              state     <= S_IDLE;
              out_valid <= 1'b1;
            end
          end
        end
        S_READ: begin
          state     <= S_IDLE;
          out_valid <= 1'b1;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A commit never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("result overwritten before transfer");

  // Queue read data is taken only the cycle after a commit that popped
  a_read_follows_commit: assert property (@(posedge clk) disable iff (rst)
    cmd.load_mem |-> ($past(cmd.commit) && $past(sts.need_read)))
    else $error("queue read without a popping commit");

  // One request in flight: no transfer right after a transfer
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while busy");

  // A queue read always produces a result
  a_read_gives_result: assert property (@(posedge clk) disable iff (rst)
    cmd.load_mem |=> out_valid)
    else $error("queue read gave no result");

endmodule

### rtl/pooled_slot_allocator.sv
// pooled_slot_allocator: top level, joins controller and datapath to the channels.
// Depends on psa_pkg, psa_if, psa_ctrl and psa_dp.
//
//   port       dir  kind          carries
//   req        in   valid/ready   func, batch, slot_offset
//   rsp        out  valid/ready   status, out_batch, out_offset
//   cfg_we     in   write strobe  cfg_wdata -> slots_per_batch
//
// A request passes through transfer, then decision and commit; a request that
// reuses a released slot adds a queue memory read after the commit.
// One request is in flight at a time; the next one is taken while the result
// still waits in the output register, which holds through rsp stalls.
// Reset is synchronous; queue memory is not cleared, so no clearing pass runs.
module pooled_slot_allocator #(
  parameter int NUM_POOLS      = psa_pkg::NUM_POOLS_DEF,
  parameter int SLOTS_PER_POOL = psa_pkg::SLOTS_PER_POOL_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  psa_req_if.sink                   req,
  psa_rsp_if.source                 rsp,
  input  logic                      cfg_we,
  input  logic [psa_pkg::CFG_W-1:0] cfg_wdata
);
  import psa_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencing and handshakes
  psa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Pool state, queue memory and result register
  psa_dp #(
    .NUM_POOLS      (NUM_POOLS),
    .SLOTS_PER_POOL (SLOTS_PER_POOL)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (req.func),
    .in_batch   (req.batch),
    .in_offset  (req.slot_offset),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .res_status (rsp.status),
    .res_batch  (rsp.out_batch),
    .res_offset (rsp.out_offset)
  );

endmodule

### dv/tb_pooled_slot_allocator.sv
`timescale 1ns / 1ps
// tb_pooled_slot_allocator: self-checking testbench for the pooled slot allocator.
// Drives requests, result stalls and the slot limit; a scoreboard predicts every result.
// Depends on psa_pkg, psa_if and the pooled_slot_allocator RTL.

import psa_pkg::*;

// One predicted result of a request
typedef struct packed {
  status_t             status;
  logic [BATCH_W-1:0]  pool;
  logic [OFFSET_W-1:0] offset;
} grant_t;

// A slot handed out and not yet given back by the stimulus
typedef struct packed {
  logic [BATCH_W-1:0]  pool;
  logic [OFFSET_W-1:0] offset;
} slot_t;

// Scoreboard: mirrors pool state and holds the results still to come
class slot_scoreboard;
  localparam int NP  = NUM_POOLS_DEF;
  localparam int SPP = SLOTS_PER_POOL_DEF;

  // mirrored allocator state
  logic [CFG_W-1:0]    limit_reg;
  int                  opened;
  int                  hw    [NP];
  logic [OFFSET_W-1:0] store [NP][SPP];
  int                  head  [NP];
  int                  tail  [NP];
  int                  depth [NP];

  grant_t expected_grants[$];
  int     requests;
  int     mismatches;
  int     status_hits[6];

  function new();
    limit_reg  = CFG_RESET;
    opened     = 0;
    requests   = 0;
    mismatches = 0;
    foreach (hw[p]) begin
      hw[p]    = 0;
      head[p]  = 0;
      tail[p]  = 0;
      depth[p] = 0;
    end
    foreach (status_hits[i]) status_hits[i] = 0;
  endfunction

  // Work out the result of an accepted request and queue it
  function grant_t log_request(logic [FUNC_W-1:0] f, logic [BATCH_W-1:0] b,
                               logic [OFFSET_W-1:0] off);
    grant_t g;
    int     lim;
    int     p;
    g.status = ST_REJECTED;
    g.pool   = '0;
    g.offset = '0;
    lim = (limit_reg == 0) ? 1 : ((limit_reg > SPP) ? SPP : int'(limit_reg));
    if (f == FUNC_ALLOC) begin
      g.status = ST_NO_SPACE;
      // lowest opened pool with a queued slot or fresh room
      p = 0;
      while (p < opened && depth[p] == 0 && hw[p] >= lim) p++;
      if (p < opened) begin
        g.pool = BATCH_W'(p);
        if (depth[p] != 0) begin
          g.status = ST_REUSED;
          g.offset = store[p][head[p]];
          head[p]  = (head[p] + 1) % SPP;
          depth[p]--;
        end else begin
          g.status = ST_FRESH;
          g.offset = OFFSET_W'(hw[p]);
          hw[p]++;
        end
      end else if (opened < NP) begin
        g.status      = ST_OPENED;
        g.pool        = BATCH_W'(opened);
        hw[opened]    = 1;
        head[opened]  = 0;
        tail[opened]  = 0;
        depth[opened] = 0;
        opened++;
      end
    end else if (b < opened && off < hw[b] && depth[b] < SPP) begin
      store[b][tail[b]] = off;
      tail[b] = (tail[b] + 1) % SPP;
      depth[b]++;
      g.status = ST_RELEASED;
    end
    expected_grants.insert(expected_grants.size(), g);
    requests++;
    return g;
  endfunction

  function void record_mismatch(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  // Compare one result transfer with the oldest prediction
  function void match_result(logic [STATUS_W-1:0] st, logic [BATCH_W-1:0] pb,
                             logic [OFFSET_W-1:0] po);
    grant_t g;
    if (expected_grants.size() == 0) begin
      record_mismatch($sformatf("result with nothing pending: status %0d pool %0d offset %0d",
                                st, pb, po));
      return;
    end
    g = expected_grants[0];
    expected_grants.delete(0);
    status_hits[g.status]++;
    if (st !== g.status || pb !== g.pool || po !== g.offset)
      record_mismatch($sformatf({"result mismatch: expected status %0d pool %0d offset %0d,",
                                 " got status %0d pool %0d offset %0d"},
                                g.status, g.pool, g.offset, st, pb, po));
  endfunction
endclass

module tb_pooled_slot_allocator;
  logic             clk;
  logic             rst;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;
  bit               bursts_on;
  int               settings_used;
  slot_t            held[$];
  slot_scoreboard   sb;

  psa_req_if req_ch();
  psa_rsp_if rsp_ch();

  pooled_slot_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the block hangs
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
      sb.match_result(rsp_ch.status, rsp_ch.out_batch, rsp_ch.out_offset);
  end

  // Result sink: random stall bursts while enabled
  initial begin
    rsp_ch.ready <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      rsp_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      if (bursts_on) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
      end
    end
  end

  // Present one request and hold it until the transfer
  task automatic send_req(logic [FUNC_W-1:0] f, logic [BATCH_W-1:0] b,
                          logic [OFFSET_W-1:0] off);
    grant_t g;
    slot_t  s;
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    req_ch.valid       <= 1'b1;
    req_ch.func        <= f;
    req_ch.batch       <= b;
    req_ch.slot_offset <= off;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    g = sb.log_request(f, b, off);
    if (g.status == ST_REUSED || g.status == ST_FRESH || g.status == ST_OPENED) begin
      s.pool   = g.pool;
      s.offset = g.offset;
      held.insert(held.size(), s);
    end
  endtask

  // Write the slot limit once the block has drained
  task automatic write_limit(logic [CFG_W-1:0] v);
    req_ch.valid <= 1'b0;
    while (sb.expected_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.limit_reg = v;
    settings_used++;
  endtask

  // Mix of allocations, proper releases of held slots, and noise
  task automatic run_mix(int n);
    slot_t s;
    int    pick;
    int    k;
    int    roll;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
        send_req(FUNC_ALLOC, BATCH_W'($urandom), OFFSET_W'($urandom));
      end else if (roll < 80 && held.size() != 0) begin
        pick = $urandom_range(0, held.size() - 1);
        s = held[pick];
        held.delete(pick);
        send_req(FUNC_RELEASE, s.pool, s.offset);
      end else if (roll < 88 && sb.opened != 0) begin
        // in-range pool, offset up to and including the high-water mark
        pick = $urandom_range(0, sb.opened - 1);
        send_req(FUNC_RELEASE, BATCH_W'(pick), OFFSET_W'($urandom_range(0, sb.hw[pick])));
      end else begin
        send_req(FUNC_RELEASE, BATCH_W'($urandom), OFFSET_W'($urandom));
      end
    end
  endtask

  // Main sequence
  initial begin
    int limits[12];
    int ph;
    sb            = new();
    settings_used = 0;
    bursts_on     = 1'b1;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    req_ch.valid       <= 1'b0;
    req_ch.func        <= FUNC_ALLOC;
    req_ch.batch       <= '0;
    req_ch.slot_offset <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset limit of 1024
    send_req(FUNC_RELEASE, 3'd0, 10'd0);       // nothing opened yet
    send_req(FUNC_ALLOC, '1, '1);              // opens pool 0
    send_req(FUNC_ALLOC, '0, '0);              // fresh slot 1
    send_req(FUNC_RELEASE, 3'd0, 10'd2);       // at the high-water mark
    send_req(FUNC_RELEASE, 3'd0, 10'd1);
    send_req(FUNC_ALLOC, '0, '0);              // reuses slot 1
    send_req(FUNC_RELEASE, 3'd7, 10'd1023);    // unopened pool, field extremes

    // Directed: limit 1, pool 0 already past it; open the rest, then run dry
    write_limit(11'd1);
    repeat (8) send_req(FUNC_ALLOC, '0, '0);
    send_req(FUNC_RELEASE, 3'd3, 10'd0);
    send_req(FUNC_ALLOC, '1, '1);              // queued slot beats the limit
    send_req(FUNC_RELEASE, 3'd7, 10'd0);
    send_req(FUNC_RELEASE, 3'd7, 10'd1);       // at the high-water mark
    send_req(FUNC_ALLOC, '0, '0);

    // Fill pool 0's free queue to the brim, overflow it, drain some, wrap the tail
    while (sb.depth[0] < SLOTS_PER_POOL_DEF) send_req(FUNC_RELEASE, 3'd0, 10'd0);
    repeat (3) send_req(FUNC_RELEASE, 3'd0, 10'd0);
    repeat (60) send_req(FUNC_ALLOC, BATCH_W'($urandom), OFFSET_W'($urandom));
    repeat (60) send_req(FUNC_RELEASE, 3'd0, OFFSET_W'($urandom_range(0, sb.hw[0] - 1)));
    held.delete();

    // Random phases across limit settings
    limits = '{3, 0, 2, 2047, 6, 1024, 1, 12, 0, 4, 2, 0};
    limits[8]  = $urandom_range(1, 2047);
    limits[11] = $urandom_range(1, 40);
    for (ph = 0; ph < 12; ph++) begin
      write_limit(CFG_W'(limits[ph]));
      run_mix(40);
    end

    // Last stretch at full rate on both sides
    write_limit(11'd2);
    bursts_on = 1'b0;
    run_mix(100);

    req_ch.valid <= 1'b0;
    while (sb.expected_grants.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Ran %0d requests over %0d limit settings, including a full pool 0 free queue.",
             sb.requests, settings_used);
    $display("Results: reused %0d, fresh %0d, opened %0d, no space %0d, released %0d, rejected %0d",
             sb.status_hits[ST_REUSED], sb.status_hits[ST_FRESH], sb.status_hits[ST_OPENED],
             sb.status_hits[ST_NO_SPACE], sb.status_hits[ST_RELEASED],
             sb.status_hits[ST_REJECTED]);
    if (sb.mismatches == 0 && sb.expected_grants.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
